// File: rtl/soa_pkg.sv
// ---------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package soa_pkg;

  localparam int unsigned DEF_PAGE_BYTES   = 4096;
  localparam int unsigned DEF_SLAB_COUNT   = 16;
  localparam int unsigned DEF_HEADER_BYTES = 40;
  localparam int unsigned DEF_MAX_OBJECTS  = 512;

  // free count per slab saturates at TOTAL_MAX
  localparam int unsigned TW        = 9;
  localparam int unsigned TOTAL_MAX = 511;

  localparam int unsigned AW  = 32;  // address width
  localparam int unsigned OBW = 12;  // object size width
  localparam int unsigned MIN_OBJECT_BYTES = 8;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOMEM    = 2'd1,
    STS_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic {
    CFG_POOL_BASE    = 1'b0,
    CFG_OBJECT_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_TAB,
    S_A_NXT,
    S_A_DIV,
    S_A_FILL,
    S_A_OPEN,
    S_MUL,
    S_ADD,
    S_F_SPAN,
    S_F_SCAN,
    S_F_DIV,
    S_F_TAB,
    S_RESULT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/slab_object_allocator_top.sv
// ---------------------------------------------------------------------------
// slab_object_allocator_top
// Fixed-size object allocator over a pool of page slabs.
// ---------------------------------------------------------------------------
// One request is worked at a time. An allocate served from an open slab runs
// through accept, slab table read, chain read and table write, multiply, add
// and result. An allocate that opens a slab first divides the page space after
// the header by the object size for a quotient QW bits wide (QW is the larger of
// log2(MAX_OBJECTS) and log2(PAGE_BYTES)), then lays down the free chain of
// the new slab in the chain memory, one object after another. A free walks
// the open slabs newest first, one slab per cycle, then divides the offset
// and updates both memories.
// A new request is taken while the previous result still waits on the output.
// The chain memory and slab table are not cleared after reset.
`timescale 1ns / 1ps
`default_nettype none

module slab_object_allocator_top
  import soa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned SLAB_COUNT   = DEF_SLAB_COUNT,
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int unsigned MAX_OBJECTS  = DEF_MAX_OBJECTS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          command_i,
  input  wire logic [31:0]   address_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic      [31:0]   object_address_o,
  output logic      [1:0]    status_o
);

  localparam int unsigned SW   = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
  localparam int unsigned OW   = $clog2(SLAB_COUNT + 1);
  localparam int unsigned IDXW = $clog2(MAX_OBJECTS);
  localparam int unsigned OPW  = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned PGL  = $clog2(PAGE_BYTES);
  localparam int unsigned QW   = (IDXW > PGL) ? IDXW : PGL;
  localparam int unsigned TABW = IDXW + TW;

  state_e state_q, state_d;

  logic [AW-1:0]         pool_base_q;
  logic [OBW-1:0]        obj_bytes_q;
  logic [OBW-1:0]        size;

  logic [OW-1:0]         open_q, open_d;
  logic [OPW-1:0]        ops_q, ops_d;
  logic [SLAB_COUNT-1:0] nonempty_q, nonempty_d;
  logic [SW-1:0]         slab_q, slab_d;
  logic [IDXW-1:0]       idx_q, idx_d;
  logic [TW-1:0]         total_q, total_d;
  logic [IDXW-1:0]       k_q, k_d;
  logic [OW-1:0]         s_q, s_d;
  logic [AW-1:0]         rel_q, rel_d;
  logic [AW-1:0]         span_q, span_d;
  logic [AW-1:0]         prod_q, prod_d;
  logic [AW-1:0]         base_q, base_d;
  logic [AW-1:0]         res_addr_q, res_addr_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [AW-1:0]         out_addr_q, out_addr_d;
  status_e               out_status_q, out_status_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  have;
  logic [SW-1:0]         found;
  logic [AW-1:0]         off_c;
  logic                  hit;
  logic [OPW-1:0]        n_new;
  logic [TW-1:0]         tot_new;

  logic                  tab_we, tab_re;
  logic [SW-1:0]         tab_waddr, tab_raddr;
  logic [TABW-1:0]       tab_wdata, tab_rdata;
  logic [IDXW-1:0]       tab_head;
  logic [TW-1:0]         tab_total;
  logic                  nf_we, nf_re;
  logic [SW+IDXW-1:0]    nf_waddr, nf_raddr;
  logic [IDXW-1:0]       nf_wdata, nf_rdata;

  logic                  div_start, div_done;
  logic [AW-1:0]         div_dividend;
  logic [QW-1:0]         div_quo;

  assign size       = (obj_bytes_q < OBW'(MIN_OBJECT_BYTES)) ? OBW'(MIN_OBJECT_BYTES)
                                                             : obj_bytes_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tab_head   = tab_rdata[TABW-1:TW];
  assign tab_total  = tab_rdata[TW-1:0];
  assign off_c      = rel_q + AW'(PAGE_BYTES);
  assign hit        = (off_c < span_q);

  // newest slab with a free object
  always_comb begin
    have  = 1'b0;
    found = '0;
    for (int i = 0; i < SLAB_COUNT; i++) begin
      if (nonempty_q[i]) begin
        have  = 1'b1;
        found = SW'(i);
      end
    end
  end

  // objects per new slab, capped
  always_comb begin
    if (32'(div_quo) > 32'(MAX_OBJECTS)) begin
      n_new = OPW'(MAX_OBJECTS);
    end else begin
      n_new = OPW'(div_quo);
    end
    if (32'(ops_q) > 32'(TOTAL_MAX)) begin
      tot_new = TW'(TOTAL_MAX - 1);
    end else begin
      tot_new = TW'(ops_q) - TW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(command_i) == CMD_FREE) begin
            state_d = S_F_SPAN;
          end else if (have) begin
            state_d = S_A_TAB;
          end else if (32'(open_q) >= 32'(SLAB_COUNT)) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_A_DIV;
          end
        end
      end
      S_A_TAB: state_d = S_A_NXT;
      S_A_NXT: state_d = S_MUL;
      S_A_DIV: begin
        if (div_done) begin
          state_d = (n_new == '0) ? S_RESULT : S_A_FILL;
        end
      end
      S_A_FILL: begin
        if (OPW'(k_q) == ops_q - OPW'(1)) begin
          state_d = S_A_OPEN;
        end
      end
      S_A_OPEN: state_d = S_MUL;
      S_MUL:    state_d = S_ADD;
      S_ADD:    state_d = S_RESULT;
      S_F_SPAN: state_d = S_F_SCAN;
      S_F_SCAN: begin
        if (s_q == '0) begin
          state_d = S_RESULT;
        end else if (hit) begin
          state_d = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          state_d = S_F_TAB;
        end
      end
      S_F_TAB: state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    open_d       = open_q;
    ops_d        = ops_q;
    nonempty_d   = nonempty_q;
    slab_d       = slab_q;
    idx_d        = idx_q;
    total_d      = total_q;
    k_d          = k_q;
    s_d          = s_q;
    rel_d        = rel_q;
    span_d       = span_q;
    prod_d       = prod_q;
    base_d       = base_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    tab_we       = 1'b0;
    tab_waddr    = slab_q;
    tab_wdata    = '0;
    tab_re       = 1'b0;
    tab_raddr    = slab_q;
    nf_we        = 1'b0;
    nf_waddr     = {slab_q, idx_q};
    nf_wdata     = '0;
    nf_re        = 1'b0;
    nf_raddr     = {slab_q, idx_q};
    div_start    = 1'b0;
    div_dividend = (state_q == S_F_SCAN) ? off_c : AW'(PAGE_BYTES - HEADER_BYTES);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(command_i) == CMD_FREE) begin
            rel_d = address_i - pool_base_q - AW'(HEADER_BYTES);
            s_d   = open_q;
          end else if (have) begin
            slab_d    = found;
            tab_re    = 1'b1;
            tab_raddr = found;
          end else if (32'(open_q) >= 32'(SLAB_COUNT)) begin
            res_addr_d   = '0;
            res_status_d = STS_NOMEM;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_A_TAB: begin
        idx_d    = tab_head;
        total_d  = tab_total;
        nf_re    = 1'b1;
        nf_raddr = {slab_q, tab_head};
      end
      S_A_NXT: begin
        tab_we             = 1'b1;
        tab_wdata          = {nf_rdata, total_q - TW'(1)};
        nonempty_d[slab_q] = (total_q != TW'(1));
      end
      S_A_DIV: begin
        if (div_done) begin
          if (n_new == '0) begin
            res_addr_d   = '0;
            res_status_d = STS_NOMEM;
          end else begin
            ops_d  = n_new;
            slab_d = open_q[SW-1:0];
            k_d    = '0;
          end
        end
      end
      S_A_FILL: begin
        // free chain in address order, last object ends it
        nf_we    = 1'b1;
        nf_waddr = {slab_q, k_q};
        if (OPW'(k_q) + OPW'(1) < ops_q) begin
          nf_wdata = k_q + IDXW'(1);
        end else begin
          nf_wdata = '0;
        end
        k_d = k_q + IDXW'(1);
      end
      S_A_OPEN: begin
        // object 0 goes out at once
        tab_we             = 1'b1;
        tab_wdata          = {((ops_q > OPW'(1)) ? IDXW'(1) : IDXW'(0)), tot_new};
        nonempty_d[slab_q] = (tot_new != '0);
        open_d             = open_q + OW'(1);
        idx_d              = '0;
      end
      S_MUL: begin
        prod_d = AW'(idx_q) * AW'(size);
        base_d = AW'(slab_q) * AW'(PAGE_BYTES);
      end
      S_ADD: begin
        res_addr_d   = pool_base_q + base_q + AW'(HEADER_BYTES) + prod_q;
        res_status_d = STS_OK;
      end
      S_F_SPAN: begin
        span_d = AW'(ops_q) * AW'(size);
        rel_d  = rel_q - AW'(open_q) * AW'(PAGE_BYTES);
      end
      S_F_SCAN: begin
        if (s_q == '0) begin
          res_addr_d   = '0;
          res_status_d = STS_NOTFOUND;
        end else if (hit) begin
          slab_d    = SW'(s_q - OW'(1));
          div_start = 1'b1;
        end else begin
          s_d   = s_q - OW'(1);
          rel_d = off_c;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          idx_d  = div_quo[IDXW-1:0];
          tab_re = 1'b1;
        end
      end
      S_F_TAB: begin
        nf_we     = 1'b1;
        nf_wdata  = tab_head;
        tab_we    = 1'b1;
        if (tab_total < TW'(TOTAL_MAX)) begin
          tab_wdata = {idx_q, tab_total + TW'(1)};
        end else begin
          tab_wdata = {idx_q, tab_total};
        end
        nonempty_d[slab_q] = 1'b1;
        res_addr_d         = '0;
        res_status_d       = STS_OK;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_base_q <= '0;
      obj_bytes_q <= OBW'(32);
      open_q      <= '0;
      ops_q       <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      ops_q       <= ops_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_POOL_BASE:    pool_base_q <= cfg_wdata_i;
          CFG_OBJECT_BYTES: obj_bytes_q <= cfg_wdata_i[OBW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slab_q       <= slab_d;
    idx_q        <= idx_d;
    total_q      <= total_d;
    k_q          <= k_d;
    s_q          <= s_d;
    rel_q        <= rel_d;
    span_q       <= span_d;
    prod_q       <= prod_d;
    base_q       <= base_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  soa_ram #(
    .WIDTH (TABW),
    .DEPTH (2 ** SW)
  ) u_slab_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  soa_ram #(
    .WIDTH (IDXW),
    .DEPTH (2 ** (SW + IDXW))
  ) u_chain (
    .clk_i   (clk_i),
    .we_i    (nf_we),
    .waddr_i (nf_waddr),
    .wdata_i (nf_wdata),
    .re_i    (nf_re),
    .raddr_i (nf_raddr),
    .rdata_o (nf_rdata)
  );

  soa_div #(
    .DW (AW),
    .VW (OBW),
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (size),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o      = out_valid_q;
  assign object_address_o = out_addr_q;
  assign status_o         = out_status_q;

endmodule

`default_nettype wire

// File: rtl/soa_ram.sv
// ---------------------------------------------------------------------------
// soa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/soa_div.sv
// ---------------------------------------------------------------------------
// soa_div
// Restoring divider, one quotient bit per cycle, for a dividend known to be
// below divisor * 2**QW.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soa_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 12,
  parameter int unsigned QW = 12,
  localparam int unsigned CW = (DW > VW + QW) ? DW : VW + QW,
  localparam int unsigned NW = $clog2(QW + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [QW-1:0] quotient_o
);

  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dsh_q, dsh_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          take;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    take   = (rem_q >= dsh_q);
    if (start_i) begin
      rem_d  = CW'(dividend_i);
      dsh_d  = CW'(divisor_i) << (QW - 1);
      cnt_d  = NW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (take) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QW-2:0], take};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
